// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held.
`define CHK_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed");

// Clocked check that stays live through reset.
`define CHK_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("reset check failed");

`endif

// ===== src/qupc_pkg.sv =====
// Shared constants and types of the user priority classifier.
package qupc_pkg;

    localparam int TABLE_ENTRIES = 16;

    localparam int PRIO_W    = 3;
    localparam int SRC_W     = 3;
    localparam int PORT_W    = 16;
    localparam int IP_KEY_W  = 8;

    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [1:0] OP_CLASSIFY = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_INVAL    = 2'd2;

    localparam logic [1:0] FK_ETH  = 2'd0;
    localparam logic [1:0] FK_IPV4 = 2'd1;
    localparam logic [1:0] FK_IPV6 = 2'd2;

    localparam logic [1:0] TS_IP  = 2'd0;
    localparam logic [1:0] TS_UDP = 2'd1;
    localparam logic [1:0] TS_TCP = 2'd2;

    localparam logic [15:0] ETHERTYPE_V4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_V6 = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;

    localparam logic [SRC_W-1:0] SRC_DEFAULT = 3'd0;
    localparam logic [SRC_W-1:0] SRC_IP      = 3'd1;
    localparam logic [SRC_W-1:0] SRC_UDP_DST = 3'd2;
    localparam logic [SRC_W-1:0] SRC_UDP_SRC = 3'd3;
    localparam logic [SRC_W-1:0] SRC_TCP_DST = 3'd4;
    localparam logic [SRC_W-1:0] SRC_TCP_SRC = 3'd5;

    localparam logic REG_DEFAULT_PRIO = 1'b0;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [1:0]        frame_kind;
        logic [15:0]       ether_type;
        logic [12:0]       frag_offset;
        logic              more_fragments;
        logic [7:0]        ip_protocol;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
        logic [1:0]        table_select;
        logic [3:0]        entry_index;
        logic [15:0]       entry_key;
        logic [PRIO_W-1:0] entry_priority;
    } qupc_req_t;

    typedef struct packed {
        logic [PRIO_W-1:0] user_priority;
        logic [SRC_W-1:0]  match_source;
    } qupc_result_t;

    typedef struct packed {
        logic         push;
        qupc_result_t res;
    } qupc_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qupc_qstat_t;

endpackage

// ===== src/qupc_front.sv =====
// Front end: accepts beats, maintains the match tables and classifies packets.
module qupc_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  qupc_pkg::qupc_req_t        req,
    input  logic [qupc_pkg::PRIO_W-1:0] default_prio,
    input  qupc_pkg::qupc_qstat_t      qstat,
    output qupc_pkg::qupc_push_t       push_out
);

    localparam int N = qupc_pkg::TABLE_ENTRIES;

    logic                          ip_valid_reg  [N];
    logic [qupc_pkg::IP_KEY_W-1:0] ip_key_reg    [N];
    logic [qupc_pkg::PRIO_W-1:0]   ip_prio_reg   [N];
    logic                          udp_valid_reg [N];
    logic [qupc_pkg::PORT_W-1:0]   udp_key_reg   [N];
    logic [qupc_pkg::PRIO_W-1:0]   udp_prio_reg  [N];
    logic                          tcp_valid_reg [N];
    logic [qupc_pkg::PORT_W-1:0]   tcp_key_reg   [N];
    logic [qupc_pkg::PRIO_W-1:0]   tcp_prio_reg  [N];

    logic fire;
    logic load;
    logic set_valid;

    logic is_v4, is_v6, have_proto, use_udp;
    logic ip_hit, dst_hit, src_hit;
    logic [qupc_pkg::PRIO_W-1:0] ip_prio, dst_prio, src_prio;
    qupc_pkg::qupc_result_t res;

    assign s_ready = !qstat.full;
    assign fire    = s_valid && s_ready;
    assign load    = fire && (req.opcode == qupc_pkg::OP_WRITE ||
                              req.opcode == qupc_pkg::OP_INVAL) &&
                     (32'(req.entry_index) < N);
    assign set_valid = (req.opcode == qupc_pkg::OP_WRITE);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            if (!aresetn) begin
                ip_valid_reg[i]  <= 1'b0;
                udp_valid_reg[i] <= 1'b0;
                tcp_valid_reg[i] <= 1'b0;
            end else if (load && 32'(req.entry_index) == i) begin
                case (req.table_select)
                    qupc_pkg::TS_IP: begin
                        // a key above 255 can never match a protocol number
                        ip_valid_reg[i] <= set_valid && (req.entry_key[15:8] == 8'd0);
                    end
                    qupc_pkg::TS_UDP: udp_valid_reg[i] <= set_valid;
                    qupc_pkg::TS_TCP: tcp_valid_reg[i] <= set_valid;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            if (load && 32'(req.entry_index) == i) begin
                case (req.table_select)
                    qupc_pkg::TS_IP: begin
                        ip_key_reg[i]  <= req.entry_key[qupc_pkg::IP_KEY_W-1:0];
                        ip_prio_reg[i] <= req.entry_priority;
                    end
                    qupc_pkg::TS_UDP: begin
                        udp_key_reg[i]  <= req.entry_key;
                        udp_prio_reg[i] <= req.entry_priority;
                    end
                    qupc_pkg::TS_TCP: begin
                        tcp_key_reg[i]  <= req.entry_key;
                        tcp_prio_reg[i] <= req.entry_priority;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign is_v4 = (req.frame_kind == qupc_pkg::FK_IPV4) ||
                   (req.frame_kind == qupc_pkg::FK_ETH &&
                    req.ether_type == qupc_pkg::ETHERTYPE_V4);
    assign is_v6 = (req.frame_kind == qupc_pkg::FK_IPV6) ||
                   (req.frame_kind == qupc_pkg::FK_ETH &&
                    req.ether_type == qupc_pkg::ETHERTYPE_V6);
    assign have_proto = is_v6 ||
                        (is_v4 && req.frag_offset == 13'd0 && !req.more_fragments);
    assign use_udp = (req.ip_protocol == qupc_pkg::PROTO_UDP);

    // Parallel compares; scanning downward leaves the lowest hit in place.
    always_comb begin
        ip_hit   = 1'b0;
        dst_hit  = 1'b0;
        src_hit  = 1'b0;
        ip_prio  = '0;
        dst_prio = '0;
        src_prio = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (ip_valid_reg[i] && ip_key_reg[i] == req.ip_protocol) begin
                ip_hit  = 1'b1;
                ip_prio = ip_prio_reg[i];
            end
            if (use_udp ? (udp_valid_reg[i] && udp_key_reg[i] == req.dst_port)
                        : (tcp_valid_reg[i] && tcp_key_reg[i] == req.dst_port)) begin
                dst_hit  = 1'b1;
                dst_prio = use_udp ? udp_prio_reg[i] : tcp_prio_reg[i];
            end
            if (use_udp ? (udp_valid_reg[i] && udp_key_reg[i] == req.src_port)
                        : (tcp_valid_reg[i] && tcp_key_reg[i] == req.src_port)) begin
                src_hit  = 1'b1;
                src_prio = use_udp ? udp_prio_reg[i] : tcp_prio_reg[i];
            end
        end
    end

    always_comb begin
        res.user_priority = default_prio;
        res.match_source  = qupc_pkg::SRC_DEFAULT;
        if (have_proto) begin
            if (ip_hit) begin
                res.user_priority = ip_prio;
                res.match_source  = qupc_pkg::SRC_IP;
            end else if (use_udp || req.ip_protocol == qupc_pkg::PROTO_TCP) begin
                if (dst_hit) begin
                    res.user_priority = dst_prio;
                    res.match_source  = use_udp ? qupc_pkg::SRC_UDP_DST
                                                : qupc_pkg::SRC_TCP_DST;
                end else if (src_hit) begin
                    res.user_priority = src_prio;
                    res.match_source  = use_udp ? qupc_pkg::SRC_UDP_SRC
                                                : qupc_pkg::SRC_TCP_SRC;
                end
            end
        end
    end

    assign push_out.push = fire && (req.opcode == qupc_pkg::OP_CLASSIFY);
    assign push_out.res  = res;

endmodule

// ===== src/qupc_fifo.sv =====
// Short result queue between the classifier front end and the output stage.
module qupc_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  qupc_pkg::qupc_push_t   push_in,
    input  logic                   pop,
    output qupc_pkg::qupc_result_t head,
    output qupc_pkg::qupc_qstat_t  qstat
);

    qupc_pkg::qupc_result_t         mem_reg [qupc_pkg::QDEPTH];
    logic [qupc_pkg::QPTR_W-1:0]    wptr_reg, wptr_next;
    logic [qupc_pkg::QPTR_W-1:0]    rptr_reg, rptr_next;
    logic [qupc_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                           do_push, do_pop;

    assign qstat.full  = (32'(count_reg) == qupc_pkg::QDEPTH);
    assign qstat.empty = (count_reg == '0);
    assign do_push = push_in.push && !qstat.full;
    assign do_pop  = pop && !qstat.empty;
    assign head    = mem_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wptr_next = (32'(wptr_reg) == qupc_pkg::QDEPTH - 1) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (32'(rptr_reg) == qupc_pkg::QDEPTH - 1) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push_in.res;
        end
    end

endmodule

// ===== src/qupc_back.sv =====
// Back end: output register that drives the result stream.
module qupc_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  qupc_pkg::qupc_result_t head,
    input  qupc_pkg::qupc_qstat_t  qstat,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output qupc_pkg::qupc_result_t m_res
);

    logic                   valid_reg;
    qupc_pkg::qupc_result_t res_reg;

    assign pop     = !qstat.empty && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_ready) begin
            valid_reg <= !qstat.empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= head;
        end
    end

endmodule

// ===== src/qos_user_priority_classifier_core.sv =====
// Top level of the QoS user priority classifier.
//
//  port group   dir  beat contents
//  s_axis       in   header fields or a table load; tuser carries the opcode
//  m_axis       out  user priority and match source, one beat per classify beat
//  apb          in   default_priority at byte address 0
//
// Throughput is one beat per cycle while the result queue has room; a classify
// beat's result is found by the table compare, then held in the result queue and the output register.
// Table lookups are 16-way parallel compares done in the accept cycle.
// Reset (aresetn low, synchronous) invalidates every table slot at once and
// sets default_priority to 0; no clearing pass is needed.
// s_tready drops only when the four-entry result queue is full behind a
// stalled output.
module qos_user_priority_classifier_core (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    // [1:0] frame_kind, [17:2] ether_type, [30:18] frag_offset,
    // [31] more_fragments, [39:32] ip_protocol, [55:40] src_port,
    // [71:56] dst_port, [73:72] table_select, [77:74] entry_index,
    // [93:78] entry_key, [96:94] entry_priority, [103:97] zero
    input  logic [103:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] user_priority, [5:3] match_source, [7:6] zero
    output logic [7:0]   m_tdata,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    qupc_pkg::qupc_req_t    req;
    qupc_pkg::qupc_push_t   push;
    qupc_pkg::qupc_qstat_t  qstat;
    qupc_pkg::qupc_result_t head;
    qupc_pkg::qupc_result_t m_res;
    logic                   pop;

    logic [qupc_pkg::PRIO_W-1:0] default_prio_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_prio_reg <= '0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == qupc_pkg::REG_DEFAULT_PRIO) begin
            default_prio_reg <= pwdata[qupc_pkg::PRIO_W-1:0];
        end
    end

    assign prdata = (paddr[2] == qupc_pkg::REG_DEFAULT_PRIO) ?
                    {{(32 - qupc_pkg::PRIO_W){1'b0}}, default_prio_reg} : 32'd0;

    assign req.opcode         = s_tuser;
    assign req.frame_kind     = s_tdata[1:0];
    assign req.ether_type     = s_tdata[17:2];
    assign req.frag_offset    = s_tdata[30:18];
    assign req.more_fragments = s_tdata[31];
    assign req.ip_protocol    = s_tdata[39:32];
    assign req.src_port       = s_tdata[55:40];
    assign req.dst_port       = s_tdata[71:56];
    assign req.table_select   = s_tdata[73:72];
    assign req.entry_index    = s_tdata[77:74];
    assign req.entry_key      = s_tdata[93:78];
    assign req.entry_priority = s_tdata[96:94];

    qupc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .req          (req),
        .default_prio (default_prio_reg),
        .qstat        (qstat),
        .push_out     (push)
    );

    qupc_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_in (push),
        .pop     (pop),
        .head    (head),
        .qstat   (qstat)
    );

    qupc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .qstat   (qstat),
        .pop     (pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (m_res)
    );

    assign m_tdata = {2'b00, m_res.match_source, m_res.user_priority};

endmodule

// ===== src/qupc_checker.sv =====
// Port-level checks of the classifier core and their bind.
`include "assert_macros.svh"

module qupc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [103:0] s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [7:0]   m_tdata,
    input logic         psel,
    input logic         penable,
    input logic         pwrite,
    input logic [2:0]   paddr,
    input logic [31:0]  pwdata,
    input logic [31:0]  prdata,
    input logic         pready
);

    // a stalled result beat holds
    `CHK_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // output is empty in the cycle after reset
    `CHK_RST(a_out_reset, aclk, !aresetn |=> !m_tvalid)

    // match source stays within its defined codes
    `CHK_CLK(a_src_code, aclk, aresetn, m_tvalid |-> m_tdata[5:3] <= qupc_pkg::SRC_TCP_SRC)

    // input back-pressure only appears behind a pending result
    `CHK_CLK(a_stall_cause, aclk, aresetn, !s_tready |-> m_tvalid)

endmodule

bind qos_user_priority_classifier_core qupc_checker u_qupc_checker (.*);
